@@ hw/rtl/pal_pkg.sv @@
`default_nettype none
package pal_pkg;

  localparam int KIND_W  = 2;
  localparam int POS_W   = 7;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 7;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_READ
  } cell_op_t;

  typedef struct packed {
    cell_op_t               op;
    logic [POS_W-1:0]       pos;
  } cell_ctrl_t;

endpackage
`default_nettype wire

@@ hw/rtl/pal_in_if.sv @@
`default_nettype none
interface pal_in_if;
  logic                             valid;
  logic                             ready;
  logic        [pal_pkg::KIND_W-1:0] kind;
  logic        [pal_pkg::POS_W-1:0]  position;
  logic signed [pal_pkg::DATA_W-1:0] item;

  modport source (output valid, kind, position, item, input ready);
  modport sink   (input valid, kind, position, item, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/pal_out_if.sv @@
`default_nettype none
interface pal_out_if;
  logic                              valid;
  logic                              ready;
  logic        [1:0]                 status;
  logic signed [pal_pkg::DATA_W-1:0] value;
  logic        [pal_pkg::COUNT_W-1:0] count;

  modport source (output valid, status, value, count, input ready);
  modport sink   (input valid, status, value, count, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/pal_cell.sv @@
`default_nettype none
module pal_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  wire logic                              clk,
  input  wire pal_pkg::cell_ctrl_t               ctrl,
  input  wire logic signed [pal_pkg::DATA_W-1:0] item,
  input  wire logic signed [pal_pkg::DATA_W-1:0] left_in,
  input  wire logic signed [pal_pkg::DATA_W-1:0] right_in,
  output logic signed      [pal_pkg::DATA_W-1:0] entry,
  output logic signed      [pal_pkg::DATA_W-1:0] tap
);

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic signed [pal_pkg::DATA_W-1:0] entry_r;
  logic signed [pal_pkg::DATA_W-1:0] entry_nxt;
  logic        [CW-1:0]              pos;

  assign pos = CW'(ctrl.pos);

  always_comb begin
    entry_nxt = entry_r;
    case (ctrl.op)
      pal_pkg::CELL_INSERT: begin
        if (MY_IDX == pos) begin
          entry_nxt = item;
        end else if (MY_IDX > pos) begin
          entry_nxt = left_in;
        end
      end
      pal_pkg::CELL_DELETE: begin
        // close the gap: everything from the deleted slot up takes its right neighbor
        if (MY_IDX >= pos) begin
          entry_nxt = right_in;
        end
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign tap   = (ctrl.op == pal_pkg::CELL_READ && MY_IDX == pos) ? entry_r : '0;

endmodule
`default_nettype wire

@@ hw/rtl/pal_read_tree.sv @@
`default_nettype none
module pal_read_tree #(
  parameter int N = 64
) (
  input  wire logic                              clk,
  input  wire logic signed [pal_pkg::DATA_W-1:0] leaf [N],
  output logic signed      [pal_pkg::DATA_W-1:0] root
);

  localparam int D = $clog2(N);
  localparam int P = 1 << D;

  // heap layout: node k has children 2k+1 and 2k+2, leaves start at P-1
  logic signed [pal_pkg::DATA_W-1:0] node_r [2*P-1];

  for (genvar k = 0; k < P - 1; k++) begin : g_inner
    always_ff @(posedge clk) begin
      node_r[k] <= node_r[2*k+1] | node_r[2*k+2];
    end
  end

  for (genvar i = 0; i < P; i++) begin : g_leaf
    if (i < N) begin : g_used
      always_ff @(posedge clk) begin
        node_r[P-1+i] <= leaf[i];
      end
    end else begin : g_pad
      always_ff @(posedge clk) begin
        node_r[P-1+i] <= '0;
      end
    end
  end

  assign root = node_r[0];

endmodule
`default_nettype wire

@@ hw/rtl/positional_array_list.sv @@
// Positional array list: an ordered list of up to CAPACITY signed 32-bit entries.
// Input channel in_ch carries kind (insert, delete, read), position and item;
// result channel out_ch carries status, value and the list length after the item.
// Both are valid/ready channels; an item moves when valid and ready are both high.
// Entries live in a row of cells. On an accepted insert or delete every cell
// picks hold, load, take-left or take-right in the same cycle, so insert, delete,
// rejected and unused kinds finish without a wait state: the result is in the output
// register on the next cycle, and a new item can be taken each cycle while the
// receiver takes results. A read gathers the selected entry through a registered
// OR tree of clog2(CAPACITY) levels; its result is loaded once the entry reaches
// the tree root, and no item is taken meanwhile.
// Input ready is low while a read is in flight or while an undelivered result
// sits in the output register and out_ch.ready is low; a stalled receiver
// therefore holds off the sender without losing anything.
// Reset (rst_n low, synchronous) empties the list and drops any pending result;
// entry contents are not cleared, they are only reachable once written.
`default_nettype none
module positional_array_list #(
  parameter int CAPACITY = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pal_in_if.sink    in_ch,
  pal_out_if.source out_ch
);

  localparam int FW  = $clog2(CAPACITY + 1);
  localparam int CW  = (FW > pal_pkg::POS_W) ? FW : pal_pkg::POS_W;
  localparam int D   = $clog2(CAPACITY);
  localparam int CNW = $clog2(D + 1);

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t                            state_r;
  logic   [CNW-1:0]                  cnt_r;
  logic   [FW-1:0]                   fill_r;
  logic   [FW-1:0]                   fill_nxt;
  logic   [1:0]                      status_nxt;
  pal_pkg::cell_op_t                 op_nxt;
  pal_pkg::cell_ctrl_t               ctrl;
  logic                              accept;
  logic                              in_ready;
  logic                              out_load;
  logic   [CW-1:0]                   pos_ext;
  logic   [CW-1:0]                   fill_ext;

  logic                              out_valid_r;
  logic   [1:0]                      out_status_r;
  logic signed [pal_pkg::DATA_W-1:0] out_value_r;
  logic   [pal_pkg::COUNT_W-1:0]     out_count_r;

  logic signed [pal_pkg::DATA_W-1:0] entry_w [CAPACITY];
  logic signed [pal_pkg::DATA_W-1:0] tap_w   [CAPACITY];
  logic signed [pal_pkg::DATA_W-1:0] root_w;

  assign in_ready    = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;

  assign pos_ext  = CW'(in_ch.position);
  assign fill_ext = CW'(fill_r);

  always_comb begin
    status_nxt = pal_pkg::ST_OK;
    op_nxt     = pal_pkg::CELL_HOLD;
    fill_nxt   = fill_r;
    case (in_ch.kind)
      pal_pkg::KIND_INSERT: begin
        if (fill_r == FW'(CAPACITY)) begin
          status_nxt = pal_pkg::ST_FULL;
        end else if (pos_ext > fill_ext) begin
          status_nxt = pal_pkg::ST_RANGE;
        end else begin
          op_nxt   = pal_pkg::CELL_INSERT;
          fill_nxt = fill_r + FW'(1);
        end
      end
      pal_pkg::KIND_DELETE: begin
        if (fill_r == '0) begin
          status_nxt = pal_pkg::ST_EMPTY;
        end else if (pos_ext >= fill_ext) begin
          status_nxt = pal_pkg::ST_RANGE;
        end else begin
          op_nxt   = pal_pkg::CELL_DELETE;
          fill_nxt = fill_r - FW'(1);
        end
      end
      pal_pkg::KIND_READ: begin
        if (fill_r == '0) begin
          status_nxt = pal_pkg::ST_EMPTY;
        end else if (pos_ext >= fill_ext) begin
          status_nxt = pal_pkg::ST_RANGE;
        end else begin
          op_nxt = pal_pkg::CELL_READ;
        end
      end
      default: status_nxt = pal_pkg::ST_OK;
    endcase
  end

  assign ctrl.op  = accept ? op_nxt : pal_pkg::CELL_HOLD;
  assign ctrl.pos = in_ch.position;

  // load a fresh result: a non-read item on acceptance, or a read once the root is ready
  assign out_load = (state_r == S_IDLE) ? (accept && op_nxt != pal_pkg::CELL_READ)
                                        : (cnt_r == '0);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [pal_pkg::DATA_W-1:0] left_w;
    logic signed [pal_pkg::DATA_W-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = entry_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = entry_w[i+1];
    end

    pal_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .item     (in_ch.item),
      .left_in  (left_w),
      .right_in (right_w),
      .entry    (entry_w[i]),
      .tap      (tap_w[i])
    );
  end

  pal_read_tree #(
    .N (CAPACITY)
  ) u_read_tree (
    .clk  (clk),
    .leaf (tap_w),
    .root (root_w)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            fill_r       <= fill_nxt;
            out_status_r <= status_nxt;
            out_value_r  <= '0;
            out_count_r  <= pal_pkg::COUNT_W'(fill_nxt);
            if (op_nxt == pal_pkg::CELL_READ) begin
              // wait for the selected entry to reach the tree root
              state_r <= S_READ;
              cnt_r   <= CNW'(D);
            end
          end
        end
        S_READ: begin
          if (cnt_r == '0) begin
            out_value_r <= root_w;
            state_r     <= S_IDLE;
          end else begin
            cnt_r <= cnt_r - CNW'(1);
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.value  = out_value_r;
  assign out_ch.count  = out_count_r;

endmodule
`default_nettype wire
